// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpc assertion failed");

`endif

// ===== rtl/scpc_pkg.sv =====
// Shared types, constants and keyword tables for the serial command PWM controller.
// No dependencies.
package scpc_pkg;

    localparam int LINE_MAX = 255;
    localparam int LEN_W    = 8;
    localparam int NUM_KW   = 4;

    localparam logic [7:0]  CHAR_CR       = 8'h0D;
    localparam logic [7:0]  CHAR_DASH     = 8'h2D;
    localparam logic [7:0]  CHAR_NUL      = 8'h00;
    localparam logic [7:0]  CASE_OFFSET   = 8'd32;
    localparam logic [15:0] PASS_CODE_RST = 16'd5467;
    localparam logic [15:0] PERIOD_RST    = 16'd1000;
    localparam logic [15:0] NUM_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        TOK_START,
        TOK_KEYWORD,
        TOK_GAP,
        TOK_NUMBER
    } tok_state_t;

    typedef enum logic [2:0] {
        KW_INFO,
        KW_PASS,
        KW_PERIOD,
        KW_WIDTH,
        KW_NONE
    } kw_t;

    typedef enum logic [3:0] {
        ST_NONE       = 4'd0,
        ST_EMPTY      = 4'd1,
        ST_UNKNOWN    = 4'd2,
        ST_INFO       = 4'd3,
        ST_PASS_OK    = 4'd4,
        ST_BAD_PASS   = 4'd5,
        ST_DENIED     = 4'd6,
        ST_PERIOD_SET = 4'd7,
        ST_WIDTH_SET  = 4'd8,
        ST_WIDTH_REJ  = 4'd9
    } status_t;

    // Parsed line, valid in the cycle a carriage return is processed.
    typedef struct packed {
        logic        eol;
        logic        empty;
        kw_t         kw;
        logic [15:0] number;
    } line_cmd_t;

    typedef struct packed {
        status_t     status;
        logic        also_denied;
        logic        pwm_level;
        logic [15:0] period;
        logic [15:0] width;
        logic        unlocked;
    } result_t;

    function automatic logic [2:0] kw_len(input logic [1:0] idx);
        logic [2:0] len;
        case (idx)
            2'd0:    len = 3'd5;
            2'd1:    len = 3'd4;
            2'd2:    len = 3'd6;
            2'd3:    len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        case ({idx, pos})
            {2'd0, 3'd0}: ch = "I";
            {2'd0, 3'd1}: ch = "N";
            {2'd0, 3'd2}: ch = "F";
            {2'd0, 3'd3}: ch = "O";
            {2'd0, 3'd4}: ch = "?";
            {2'd1, 3'd0}: ch = "P";
            {2'd1, 3'd1}: ch = "A";
            {2'd1, 3'd2}: ch = "S";
            {2'd1, 3'd3}: ch = "S";
            {2'd2, 3'd0}: ch = "P";
            {2'd2, 3'd1}: ch = "E";
            {2'd2, 3'd2}: ch = "R";
            {2'd2, 3'd3}: ch = "I";
            {2'd2, 3'd4}: ch = "O";
            {2'd2, 3'd5}: ch = "D";
            {2'd3, 3'd0}: ch = "W";
            {2'd3, 3'd1}: ch = "I";
            {2'd3, 3'd2}: ch = "D";
            {2'd3, 3'd3}: ch = "T";
            {2'd3, 3'd4}: ch = "H";
            default:      ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/scpc_parser.sv =====
// Line parser: keyword matching and decimal accumulation, one byte per step.
// Depends on scpc_pkg.
module scpc_parser import scpc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       is_byte,
    input  logic [7:0] rx_byte,
    output line_cmd_t  cmd
);

    logic [LEN_W-1:0] len_reg, len_next;
    tok_state_t       tok_reg, tok_next;
    logic [2:0]       pos_reg, pos_next;
    logic [NUM_KW-1:0] cand_reg, cand_next;
    logic [15:0]      num_reg, num_next;
    logic             done_reg, done_next;

    logic [7:0]        up_char;
    logic              is_dash;
    logic              is_digit;
    logic              eol;
    logic              take;
    logic [NUM_KW-1:0] cand_kw;
    logic [2:0]        pos_kw;
    logic [19:0]       num_ext;
    logic [19:0]       num_sum;
    logic [15:0]       num_sat;

    always_comb begin
        up_char  = (rx_byte inside {[8'h61:8'h7A]}) ? rx_byte - CASE_OFFSET : rx_byte;
        is_dash  = (rx_byte == CHAR_DASH);
        is_digit = (rx_byte inside {[8'h30:8'h39]});
        eol      = step && is_byte && (rx_byte == CHAR_CR);
        take     = step && is_byte && (rx_byte != CHAR_CR) && (rx_byte != CHAR_NUL)
                   && (len_reg < LEN_W'(LINE_MAX));
        for (int i = 0; i < NUM_KW; i++) begin
            cand_kw[i] = cand_reg[i] && (pos_reg < kw_len(2'(i)))
                         && (kw_char(2'(i), pos_reg) == up_char);
        end
        pos_kw  = (pos_reg == 3'd7) ? pos_reg : pos_reg + 3'd1;
        num_ext = {4'd0, num_reg};
        num_sum = (num_ext << 3) + (num_ext << 1) + {16'd0, rx_byte[3:0]};
        num_sat = (num_sum > {4'd0, NUM_MAX}) ? NUM_MAX : num_sum[15:0];
    end

    // next state
    always_comb begin
        len_next  = len_reg;
        tok_next  = tok_reg;
        pos_next  = pos_reg;
        cand_next = cand_reg;
        num_next  = num_reg;
        done_next = done_reg;
        if (eol) begin
            len_next  = '0;
            tok_next  = TOK_START;
            pos_next  = '0;
            cand_next = '1;
            num_next  = '0;
            done_next = 1'b0;
        end else if (take) begin
            len_next = len_reg + LEN_W'(1);
            case (tok_reg)
                TOK_START: begin
                    if (!is_dash) begin
                        tok_next  = TOK_KEYWORD;
                        cand_next = cand_kw;
                        pos_next  = pos_kw;
                    end
                end
                TOK_KEYWORD: begin
                    if (is_dash) begin
                        tok_next = TOK_GAP;
                    end else begin
                        cand_next = cand_kw;
                        pos_next  = pos_kw;
                    end
                end
                TOK_GAP: begin
                    if (!is_dash) begin
                        tok_next = TOK_NUMBER;
                        if (is_digit) begin
                            num_next = num_sat;
                        end else begin
                            done_next = 1'b1;
                        end
                    end
                end
                default: begin
                    if (!done_reg) begin
                        if (is_digit) begin
                            num_next = num_sat;
                        end else begin
                            done_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        cmd.eol    = eol;
        cmd.empty  = (len_reg == '0);
        cmd.number = num_reg;
        cmd.kw     = KW_NONE;
        if (tok_reg != TOK_START) begin
            for (int i = NUM_KW - 1; i >= 0; i--) begin
                if (cand_reg[i] && (pos_reg == kw_len(2'(i)))) begin
                    cmd.kw = kw_t'(3'(i));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            tok_reg  <= TOK_START;
            pos_reg  <= '0;
            cand_reg <= '1;
            num_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            len_reg  <= len_next;
            tok_reg  <= tok_next;
            pos_reg  <= pos_next;
            cand_reg <= cand_next;
            num_reg  <= num_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== rtl/scpc_exec.sv =====
// Command execution, unlock flag, pass code register and PWM counter.
// Depends on scpc_pkg; takes parsed lines from scpc_parser.
module scpc_exec import scpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_pass_code,
    input  logic        step,
    input  logic        is_tick,
    input  line_cmd_t   cmd,
    output result_t     res
);

    logic [15:0] pass_code_reg;
    logic [15:0] period_reg, period_next;
    logic [15:0] width_reg, width_next;
    logic        unlock_reg, unlock_next;
    logic [15:0] count_reg, count_next;

    logic [15:0] cycle_len;
    status_t     status;
    logic        den;

    always_comb begin
        period_next = period_reg;
        width_next  = width_reg;
        unlock_next = unlock_reg;
        count_next  = count_reg;
        status      = ST_NONE;
        den         = 1'b0;
        cycle_len   = (period_reg > width_reg) ? period_reg : width_reg;
        if (step && is_tick) begin
            if (width_reg == '0) begin
                count_next = '0;
            end else if (({1'b0, count_reg} + 17'd1) >= {1'b0, cycle_len}) begin
                count_next = '0;
            end else begin
                count_next = count_reg + 16'd1;
            end
        end else if (cmd.eol) begin
            if (cmd.empty) begin
                status = ST_EMPTY;
            end else begin
                case (cmd.kw)
                    KW_INFO: status = ST_INFO;
                    KW_PASS: begin
                        if (cmd.number == pass_code_reg) begin
                            unlock_next = !unlock_reg;
                            status      = ST_PASS_OK;
                        end else begin
                            status = ST_BAD_PASS;
                        end
                        den = !unlock_next;
                    end
                    KW_PERIOD: begin
                        if (!unlock_reg) begin
                            status = ST_DENIED;
                        end else begin
                            period_next = cmd.number;
                            status      = ST_PERIOD_SET;
                        end
                    end
                    KW_WIDTH: begin
                        if (!unlock_reg) begin
                            status = ST_DENIED;
                        end else if (cmd.number > period_reg) begin
                            status = ST_WIDTH_REJ;
                        end else begin
                            width_next = cmd.number;
                            status     = ST_WIDTH_SET;
                        end
                    end
                    default: status = ST_UNKNOWN;
                endcase
            end
        end
    end

    always_comb begin
        res.status      = status;
        res.also_denied = den;
        res.pwm_level   = (width_next != '0) && (count_next < width_next);
        res.period      = period_next;
        res.width       = width_next;
        res.unlocked    = unlock_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_code_reg <= PASS_CODE_RST;
            period_reg    <= PERIOD_RST;
            width_reg     <= '0;
            unlock_reg    <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (cfg_we) begin
                pass_code_reg <= cfg_pass_code;
            end
            period_reg <= period_next;
            width_reg  <= width_next;
            unlock_reg <= unlock_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/serial_command_pwm_controller_core.sv =====
// Top level of the serial command PWM controller: input register, parser,
// executor and result register. Depends on scpc_pkg, scpc_parser, scpc_exec.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | s_valid s_ready s_req_type s_rx_byte    | in
//   result  | m_valid m_ready m_status m_also_denied  | out
//           | m_pwm_level m_period_now m_width_now    |
//           | m_unlocked                              |
//   config  | cfg_valid cfg_ready cfg_pass_code       | in
//
// One request per cycle sustained while m_ready is high; a request passes the input
// register, then the result register, before its result is presented. Parser and
// executor state are updated in the single cycle a request leaves the input register.
// Reset: parser cleared, pass code 5467, period 1000, width 0, locked. While m_ready
// is low the result holds and one more request is buffered.
module serial_command_pwm_controller_core import scpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic        m_also_denied,
    output logic        m_pwm_level,
    output logic [15:0] m_period_now,
    output logic [15:0] m_width_now,
    output logic        m_unlocked,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_pass_code
);

`include "assert_macros.svh"

    logic       in_valid_reg, in_valid_next;
    logic       in_type_reg;
    logic [7:0] in_byte_reg;
    logic       m_valid_reg, m_valid_next;
    result_t    res_reg;

    logic       advance;
    line_cmd_t  cmd;
    result_t    res;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    scpc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .is_byte (!in_type_reg),
        .rx_byte (in_byte_reg),
        .cmd     (cmd)
    );

    scpc_exec u_exec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_pass_code (cfg_pass_code),
        .step          (advance),
        .is_tick       (in_type_reg),
        .cmd           (cmd),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg <= s_req_type;
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = res_reg.status;
    assign m_also_denied = res_reg.also_denied;
    assign m_pwm_level   = res_reg.pwm_level;
    assign m_period_now  = res_reg.period;
    assign m_width_now   = res_reg.width;
    assign m_unlocked    = res_reg.unlocked;

    `SCPC_ASSERT_NOW(a_denied_after_pass, aclk, aresetn, m_valid && m_also_denied,
        (m_status == ST_PASS_OK || m_status == ST_BAD_PASS) && !m_unlocked)
    `SCPC_ASSERT_NOW(a_level_needs_width, aclk, aresetn, m_valid && m_pwm_level,
        m_width_now != 16'd0)
    `SCPC_ASSERT_NOW(a_width_within_period, aclk, aresetn, m_valid && m_status == ST_WIDTH_SET,
        m_width_now <= m_period_now)
    `SCPC_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, m_valid)

endmodule

// ===== tb/tb_serial_command_pwm_controller_core.sv =====
// Self-checking testbench for serial_command_pwm_controller_core: command lines, PWM ticks and
// pass code writes with random idling on the request and result channels, checked against an
// in-bench predictor. Depends on scpc_pkg and the core RTL.
module tb_serial_command_pwm_controller_core;
    import scpc_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic        m_also_denied;
    logic        m_pwm_level;
    logic [15:0] m_period_now;
    logic [15:0] m_width_now;
    logic        m_unlocked;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_pass_code = 16'h0000;

    serial_command_pwm_controller_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_also_denied (m_also_denied),
        .m_pwm_level   (m_pwm_level),
        .m_period_now  (m_period_now),
        .m_width_now   (m_width_now),
        .m_unlocked    (m_unlocked),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_pass_code (cfg_pass_code)
    );

    always #5 aclk = ~aclk;

    // predictor state
    string       kw_name [NUM_KW] = '{"INFO?", "PASS", "PERIOD", "WIDTH"};
    logic [15:0] code_model;
    logic [7:0]  len_model;
    tok_state_t  tok_model;
    logic [2:0]  kw_pos;
    logic [3:0]  kw_live;
    logic [15:0] num_model;
    logic        num_end;
    logic [15:0] period_model;
    logic [15:0] width_model;
    logic [15:0] pwm_cnt;
    logic        unlock_model;

    result_t     pending_results[$];
    result_t     want;
    logic [7:0]  line_buf[$];

    int errors = 0;
    int items_sent = 0;
    int n_lines = 0;
    int n_ticks = 0;
    int n_results = 0;
    int n_codes = 0;
    int n_width_set = 0;
    int n_period_set = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit send_idle = 1'b1;
    bit sink_idle = 1'b1;

    function automatic int pick_gap(input bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic void line_clear();
        len_model = '0;
        tok_model = TOK_START;
        kw_pos    = '0;
        kw_live   = '1;
        num_model = '0;
        num_end   = 1'b0;
    endfunction

    function automatic void keyword_feed(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= "a" && c <= "z") ? c - CASE_OFFSET : c;
        for (int i = 0; i < NUM_KW; i++) begin
            if (int'(kw_pos) >= kw_name[i].len() || kw_name[i][int'(kw_pos)] != u)
                kw_live[i] = 1'b0;
        end
        if (kw_pos != 3'd7) kw_pos = kw_pos + 3'd1;
    endfunction

    function automatic void digit_feed(input logic [7:0] c);
        int acc;
        if (num_end) return;
        if (c < "0" || c > "9") begin
            num_end = 1'b1;
            return;
        end
        acc = int'(num_model) * 10 + int'(c - "0");
        num_model = (acc > 65535) ? NUM_MAX : acc[15:0];
    endfunction

    // Advances the predictor by one request and returns the result it must produce.
    function automatic result_t apply_request(input logic typ, input logic [7:0] c,
                                              output bit counted);
        result_t r;
        status_t st;
        logic    den;
        logic    dash;
        kw_t     hit;
        int      span;
        st = ST_NONE;
        den = 1'b0;
        counted = 1'b1;
        hit = KW_NONE;
        dash = (c == CHAR_DASH);
        if (typ) begin
            if (width_model == 0) begin
                pwm_cnt = '0;
            end else begin
                span = (period_model > width_model) ? int'(period_model) : int'(width_model);
                if (int'(pwm_cnt) + 1 >= span) pwm_cnt = '0;
                else pwm_cnt = pwm_cnt + 16'd1;
            end
        end else if (c == CHAR_CR) begin
            if (len_model == 0) begin
                st = ST_EMPTY;
            end else begin
                if (tok_model != TOK_START) begin
                    for (int i = NUM_KW - 1; i >= 0; i--)
                        if (kw_live[i] && int'(kw_pos) == kw_name[i].len()) hit = kw_t'(i);
                end
                case (hit)
                    KW_NONE: st = ST_UNKNOWN;
                    KW_INFO: st = ST_INFO;
                    KW_PASS: begin
                        if (num_model == code_model) begin
                            unlock_model = !unlock_model;
                            st = ST_PASS_OK;
                        end else begin
                            st = ST_BAD_PASS;
                        end
                        den = !unlock_model;
                    end
                    default: begin
                        if (!unlock_model) begin
                            st = ST_DENIED;
                        end else if (hit == KW_PERIOD) begin
                            period_model = num_model;
                            st = ST_PERIOD_SET;
                        end else if (num_model > period_model) begin
                            st = ST_WIDTH_REJ;
                        end else begin
                            width_model = num_model;
                            st = ST_WIDTH_SET;
                        end
                    end
                endcase
            end
            line_clear();
        end else if (c != CHAR_NUL && len_model < LINE_MAX) begin
            len_model = len_model + 8'd1;
            case (tok_model)
                TOK_START: if (!dash) begin
                    tok_model = TOK_KEYWORD;
                    keyword_feed(c);
                end
                TOK_KEYWORD: if (dash) tok_model = TOK_GAP; else keyword_feed(c);
                TOK_GAP: if (!dash) begin
                    tok_model = TOK_NUMBER;
                    digit_feed(c);
                end
                default: if (dash) num_end = 1'b1; else digit_feed(c);
            endcase
        end else begin
            counted = 1'b0;
        end
        r = '0;
        r.status      = st;
        r.also_denied = den;
        r.pwm_level   = (width_model != 0) && (pwm_cnt < width_model);
        r.period      = period_model;
        r.width       = width_model;
        r.unlocked    = unlock_model;
        return r;
    endfunction

    task automatic send_req(input logic typ, input logic [7:0] c);
        int      gap;
        bit      counted;
        result_t r;
        gap = pick_gap(send_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= typ;
        s_rx_byte  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = apply_request(typ, c, counted);
        pending_results.push_back(r);
        if (counted) items_sent++;
        if (typ) n_ticks++;
        else if (c == CHAR_CR) n_lines++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_pass_code(input logic [15:0] v);
        settle();
        cfg_valid     <= 1'b1;
        cfg_pass_code <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        code_model = v;
        n_codes++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_req(1'b0, s[i]);
        send_req(1'b0, CHAR_CR);
    endtask

    task automatic push_text(input string s, input bit mix);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (mix && ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
                ch = ch + CASE_OFFSET;
            line_buf.push_back(ch);
        end
    endtask

    // line_buf out, ticks mixed in now and then, then the carriage return
    task automatic send_buf();
        foreach (line_buf[i]) begin
            if ($urandom_range(0, 7) == 0) send_req(1'b1, 8'($urandom_range(0, 255)));
            send_req(1'b0, line_buf[i]);
        end
        send_req(1'b0, CHAR_CR);
    endtask

    task automatic rand_command();
        int    kw;
        int    r;
        int    v;
        string word;
        line_buf.delete();
        if ($urandom_range(0, 9) >= 7) repeat ($urandom_range(1, 3)) line_buf.push_back(CHAR_DASH);
        kw = $urandom_range(0, NUM_KW - 1);
        word = kw_name[kw];
        r = $urandom_range(0, 99);
        if (r < 6) word = word.substr(0, word.len() - 2);
        else if (r < 9) word = {word, "S"};
        else if (r < 11) word = {word, "XYZ"};
        if (r >= 96) repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(33, 126)));
        else push_text(word, 1'b1);
        case (kw_t'(kw))
            KW_INFO:   v = $urandom_range(0, 99);
            KW_PASS:   v = ($urandom_range(0, 3) != 0) ? int'(code_model)
                                                       : $urandom_range(0, 65535);
            KW_PERIOD: v = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 24)
                                                       : $urandom_range(0, 65535);
            default:   v = $urandom_range(0, int'(period_model) + 3);
        endcase
        r = $urandom_range(0, 99);
        if (r >= 8) begin
            repeat (($urandom_range(0, 9) < 8) ? 1 : $urandom_range(2, 3))
                line_buf.push_back(CHAR_DASH);
            if (r < 13) push_text("0", 1'b0);
            if (r >= 95) push_text("1234567", 1'b0);
            else push_text($sformatf("%0d", v), 1'b0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                line_buf.push_back(CHAR_DASH);
                push_text($sformatf("%0d", $urandom_range(0, 99)), 1'b0);
            end else if (r < 15) begin
                line_buf.push_back(8'($urandom_range(33, 126)));
                push_text("7", 1'b0);
            end
        end
        send_buf();
        repeat ($urandom_range(0, 12)) send_req(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic rand_noise();
        repeat ($urandom_range(1, 6))
            send_req($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) send_req(1'b0, CHAR_CR);
    endtask

    task automatic run_random(input int target);
        int r;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 78) rand_command();
            else if (r < 95) rand_noise();
            else if (r < 99) repeat ($urandom_range(1, 20)) send_req(1'b1, 8'($urandom_range(0, 255)));
            else settle();
            if ($urandom_range(0, 19) == 0) send_idle = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 19) == 0) sink_idle = ($urandom_range(0, 2) != 0);
        end
    endtask

    task automatic test_parser_basics();
        write_pass_code(16'h0000);
        send_req(1'b0, CHAR_CR);
        send_req(1'b0, CHAR_NUL);
        send_req(1'b0, CHAR_DASH);
        send_req(1'b0, 8'hFF);
        send_req(1'b0, CHAR_CR);
        send_line("--");
        send_line("info?");
        send_line("Width-1");
        send_line("pass");
        send_line("PERIOD-2");
        send_req(1'b1, 8'h00);
        send_req(1'b1, 8'hFF);
    endtask

    task automatic test_max_code();
        write_pass_code(16'hFFFF);
        run_random(260);
    endtask

    // "PASS" plus dashes fills the line; the code digits fall past the limit and are dropped
    task automatic test_long_line();
        send_req(1'b0, CHAR_CR);
        line_buf.delete();
        push_text("PASS", 1'b0);
        repeat (LINE_MAX - 4) line_buf.push_back(CHAR_DASH);
        push_text($sformatf("%0d", code_model), 1'b0);
        send_buf();
    endtask

    task automatic test_random_code();
        write_pass_code(16'($urandom_range(1, 65534)));
        test_long_line();
        run_random(480);
    endtask

    task automatic test_zero_code();
        write_pass_code(16'h0000);
        run_random(660);
    endtask

    task automatic test_reset_code();
        write_pass_code(PASS_CODE_RST);
        run_random(850);
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap(sink_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d", m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (want.status == ST_WIDTH_SET) n_width_set++;
                if (want.status == ST_PERIOD_SET) n_period_set++;
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    errors++;
                end
                if (m_also_denied !== want.also_denied) begin
                    $error("also_denied: expected %0d, got %0d", want.also_denied, m_also_denied);
                    errors++;
                end
                if (m_pwm_level !== want.pwm_level) begin
                    $error("pwm_level: expected %0d, got %0d", want.pwm_level, m_pwm_level);
                    errors++;
                end
                if (m_period_now !== want.period) begin
                    $error("period_now: expected %0d, got %0d", want.period, m_period_now);
                    errors++;
                end
                if (m_width_now !== want.width) begin
                    $error("width_now: expected %0d, got %0d", want.width, m_width_now);
                    errors++;
                end
                if (m_unlocked !== want.unlocked) begin
                    $error("unlocked: expected %0d, got %0d", want.unlocked, m_unlocked);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("watchdog: nothing moved for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        code_model   = PASS_CODE_RST;
        period_model = PERIOD_RST;
        width_model  = '0;
        unlock_model = 1'b0;
        pwm_cnt      = '0;
        line_clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_parser_basics();
        test_max_code();
        test_random_code();
        test_zero_code();
        test_reset_code();

        settle();
        repeat (10) @(posedge aclk);
        $display("Covered %0d requests: %0d command lines, %0d ticks, %0d results checked",
                 items_sent, n_lines, n_ticks, n_results);
        $display("%0d pass code settings, %0d period updates, %0d width updates",
                 n_codes, n_period_set, n_width_set);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== serial_command_pwm_controller_core.f =====
+incdir+rtl
rtl/scpc_pkg.sv
rtl/scpc_parser.sv
rtl/scpc_exec.sv
rtl/serial_command_pwm_controller_core.sv
tb/tb_serial_command_pwm_controller_core.sv
